// ----- rtl/utf8_to_utf16_transcoder_top_defines.svh -----
// Assertion macros for the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define UTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define UTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/utt_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`default_nettype none

package utt_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned UNIT_W = 16;

    localparam logic [CP_W-1:0]   MIN_CP_2B   = 21'h00080;
    localparam logic [CP_W-1:0]   MIN_CP_3B   = 21'h00800;
    localparam logic [CP_W-1:0]   ASTRAL_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR     = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR     = 16'hDC00;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // Work handed from the decoder to the unit emitter.
    typedef enum logic [1:0] {
        JOB_UNIT = 2'd0,   // one code unit
        JOB_PAIR = 2'd1,   // surrogate pair
        JOB_END  = 2'd2    // end of string, no unit
    } job_kind_t;

    typedef struct packed {
        job_kind_t       kind;
        logic [CP_W-1:0] cp;
        logic            last;
        logic            mal;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/utt_front.sv -----
// Byte decoder: gathers UTF-8 sequences and emits one job per result group.
`default_nettype none

module utt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic          full,
    input  wire logic [7:0]    in_byte,
    input  wire logic          last_byte,
    output utt_pkg::job_t      job,
    output logic               job_valid
);
    import utt_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      remain_reg, remain_next;
    logic [2:0]      seqlen_reg, seqlen_next;
    logic            halted_reg, halted_next;

    logic            accept;
    logic            have_cp;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] min_cp;

    assign accept  = push && !full;
    assign shifted = {partial_reg[CP_W-7:0], in_byte[5:0]};

    always_comb
    begin
        case (seqlen_reg)
            SEQ_LEN_2: min_cp = MIN_CP_2B;
            SEQ_LEN_3: min_cp = MIN_CP_3B;
            default:   min_cp = ASTRAL_BASE;
        endcase
    end

    // Decode the byte against the sequence in progress.
    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        seqlen_next  = seqlen_reg;
        halted_next  = halted_reg;
        have_cp      = 1'b0;
        cp           = '0;
        if (!halted_reg)
        begin
            if (remain_reg == 2'd0)
            begin
                if (!in_byte[7])
                begin
                    cp      = {13'd0, in_byte};
                    have_cp = 1'b1;
                end
                else if (in_byte[7:5] == 3'b110)
                begin
                    partial_next = {16'd0, in_byte[4:0]};
                    remain_next  = 2'd1;
                    seqlen_next  = SEQ_LEN_2;
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    partial_next = {17'd0, in_byte[3:0]};
                    remain_next  = 2'd2;
                    seqlen_next  = SEQ_LEN_3;
                end
                else if (in_byte[7:3] == 5'b11110)
                begin
                    partial_next = {18'd0, in_byte[2:0]};
                    remain_next  = 2'd3;
                    seqlen_next  = SEQ_LEN_4;
                end
                else
                begin
                    halted_next = 1'b1;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                partial_next = shifted;
                remain_next  = remain_reg - 2'd1;
                if (remain_reg == 2'd1)
                begin
                    if (shifted < min_cp)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        cp      = shifted;
                        have_cp = 1'b1;
                    end
                end
            end
        end
    end

    // Form the job for the emitter.
    always_comb
    begin
        job.cp   = cp;
        job.last = last_byte;
        job.mal  = 1'b0;
        if (have_cp)
        begin
            job.kind = (cp[CP_W-1:UNIT_W] != '0) ? JOB_PAIR : JOB_UNIT;
        end
        else
        begin
            job.kind = JOB_END;
            job.mal  = halted_next || (remain_next != 2'd0);
        end
    end

    assign job_valid = accept && (have_cp || last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= '0;
            seqlen_reg  <= '0;
            halted_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                partial_reg <= '0;
                remain_reg  <= '0;
                seqlen_reg  <= '0;
                halted_reg  <= 1'b0;
            end
            else
            begin
                partial_reg <= partial_next;
                remain_reg  <= remain_next;
                seqlen_reg  <= seqlen_next;
                halted_reg  <= halted_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utt_queue.sv -----
// Small job queue between the decoder and the emitter.
`default_nettype none

module utt_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  utt_pkg::job_t      job_in,
    output logic               full,
    input  wire logic          pop,
    output utt_pkg::job_t      job_out,
    output logic               empty
);
    import utt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utt_back.sv -----
// Code unit emitter: turns queued jobs into UTF-16 result words.
`default_nettype none
`include "utf8_to_utf16_transcoder_top_defines.svh"

module utt_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  utt_pkg::job_t      job,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [15:0]        code_unit,
    output logic               unit_valid,
    output logic               run_last,
    output logic               end_of_string,
    output logic               malformed
);
    import utt_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [UNIT_W-1:0] out_unit_reg, out_unit_next;
    logic              out_uvalid_reg, out_uvalid_next;
    logic              out_run_last_reg, out_run_last_next;
    logic              out_eos_reg, out_eos_next;
    logic              out_mal_reg, out_mal_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [UNIT_W-1:0] pend_unit_reg, pend_unit_next;
    logic              pend_last_reg, pend_last_next;

    logic              slot_free;
    logic [CP_W-1:0]   adj;
    logic [UNIT_W-1:0] hi_unit, lo_unit;

    assign slot_free = !out_valid_reg || pop;
    assign q_pop     = slot_free && !pend_valid_reg && !q_empty;
    assign adj       = job.cp - ASTRAL_BASE;
    assign hi_unit   = HI_SURR + {5'd0, adj[CP_W-1:10]};
    assign lo_unit   = LO_SURR | {6'd0, adj[9:0]};

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_unit_next     = out_unit_reg;
        out_uvalid_next   = out_uvalid_reg;
        out_run_last_next = out_run_last_reg;
        out_eos_next      = out_eos_reg;
        out_mal_next      = out_mal_reg;
        pend_valid_next   = pend_valid_reg;
        pend_unit_next    = pend_unit_reg;
        pend_last_next    = pend_last_reg;
        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                // Advance the low surrogate held back from the last pair.
                out_valid_next    = 1'b1;
                out_unit_next     = pend_unit_reg;
                out_uvalid_next   = 1'b1;
                out_run_last_next = 1'b1;
                out_eos_next      = pend_last_reg;
                out_mal_next      = 1'b0;
                pend_valid_next   = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next    = 1'b1;
                out_unit_next     = '0;
                out_uvalid_next   = 1'b0;
                out_run_last_next = 1'b1;
                out_eos_next      = 1'b0;
                out_mal_next      = 1'b0;
                case (job.kind)
                    JOB_UNIT:
                    begin
                        out_unit_next   = job.cp[UNIT_W-1:0];
                        out_uvalid_next = 1'b1;
                        out_eos_next    = job.last;
                    end
                    JOB_PAIR:
                    begin
                        out_unit_next     = hi_unit;
                        out_uvalid_next   = 1'b1;
                        out_run_last_next = 1'b0;
                        pend_valid_next   = 1'b1;
                        pend_unit_next    = lo_unit;
                        pend_last_next    = job.last;
                    end
                    JOB_END:
                    begin
                        out_eos_next = 1'b1;
                        out_mal_next = job.mal;
                    end
                    default:
                    begin
                        out_valid_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg     <= out_unit_next;
        out_uvalid_reg   <= out_uvalid_next;
        out_run_last_reg <= out_run_last_next;
        out_eos_reg      <= out_eos_next;
        out_mal_reg      <= out_mal_next;
        pend_unit_reg    <= pend_unit_next;
        pend_last_reg    <= pend_last_next;
    end

    assign empty         = !out_valid_reg;
    assign code_unit     = out_unit_reg;
    assign unit_valid    = out_uvalid_reg;
    assign run_last      = out_run_last_reg;
    assign end_of_string = out_eos_reg;
    assign malformed     = out_mal_reg;

    // A held low half always sits behind a shown high half (0xD800..0xDFFF,
    // code points above 0x10FFFF reach into the upper part of that range).
    `UTT_ASSERT_IMPL(a_pend_behind_high, clk, rst_n, pend_valid_reg, out_valid_reg && out_uvalid_reg && !out_run_last_reg && (out_unit_reg[15:11] == 5'b11011))
    // Taking the high half brings up the matching low half next.
    `UTT_ASSERT_NEXT(a_low_follows, clk, rst_n, pend_valid_reg && pop, out_valid_reg && out_run_last_reg && (out_unit_reg[15:10] == 6'b110111))
    // No job is drawn from the queue while a low half is held.
    `UTT_ASSERT_IMPL(a_no_pop_pending, clk, rst_n, pend_valid_reg, !q_pop)

endmodule

`default_nettype wire

// ----- rtl/utf8_to_utf16_transcoder_top.sv -----
// UTF-8 to UTF-16 transcoder top level: decoder, job queue and unit emitter.
// Path: an accepted byte's job is written into the queue, then into the emitter's output register.
// Throughput: one byte per cycle while full is low; one result word leaves per cycle while pop
// is held and jobs are queued, so a pair yields two words.
// The job queue (QUEUE_DEPTH entries) lets the decoder run while the emitter waits.
// Reset: asynchronous, active low; clears decoder state, queue and output valid flags.
`default_nettype none

module utf8_to_utf16_transcoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      code_unit,
    output logic             unit_valid,
    output logic             run_last,
    output logic             end_of_string,
    output logic             malformed
);
    import utt_pkg::*;

    // Decoder to queue: one job per byte that yields results.
    job_t job_in;
    logic job_in_valid;

    // Queue to emitter.
    job_t job_out;
    logic q_empty;
    logic q_pop;

    // Front: classify each byte and track the open sequence.
    utt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .job       (job_in),
        .job_valid (job_in_valid)
    );

    // Queue: hold decoded jobs so either side can stall alone.
    utt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_in_valid),
        .job_in  (job_in),
        .full    (full),
        .pop     (q_pop),
        .job_out (job_out),
        .empty   (q_empty)
    );

    // Back: expand jobs into one or two words behind an output register.
    utt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job_out),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .code_unit     (code_unit),
        .unit_valid    (unit_valid),
        .run_last      (run_last),
        .end_of_string (end_of_string),
        .malformed     (malformed)
    );

endmodule

`default_nettype wire
